FILE: src/sine_harmonic_correlator_core_assert.svh
// Assertion macros shared by the correlator checker.
`ifndef SINE_HARMONIC_CORRELATOR_CORE_ASSERT_SVH
`define SINE_HARMONIC_CORRELATOR_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low
`define SHC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sine harmonic correlator check failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low
`define SHC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sine harmonic correlator check failed");

`endif

FILE: src/shc_pkg.sv
// Types and constants of the sine harmonic correlator.
package shc_pkg;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PHASE_SHIFT   = 2'd0,
    CFG_HARMONIC_GAIN = 2'd1,
    CFG_MEAN_LEVEL    = 2'd2
  } cfg_index_e;

  localparam int CFG_DATA_W = 16;
  localparam logic [15:0] HARMONIC_GAIN_RESET = 16'd256;

  // Phase is 16-bit turns: two quadrant bits over a 14-bit offset
  localparam int PHASE_W  = 16;
  localparam int OFFSET_W = 14;

  localparam int SAMPLE_W     = 16;
  localparam int SINE_MAG_W   = 15;
  localparam int PRODUCT_W    = 32;
  localparam int SINE_SUM_W   = 32;
  localparam int PROD_SUM_W   = 48;
  localparam int MEAN_PROD_W  = 48;
  localparam int CORR_W       = 53;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Fixed-point constants for building the quarter-wave table
  localparam longint unsigned Q30_ONE      = 64'd1 << 30;
  localparam longint unsigned Q30_HALF_LSB = 64'd1 << 29;
  localparam longint unsigned HALF_PI_Q30  = 64'd1686629713;
  localparam longint unsigned SINE_MAX     = 64'd32767;
  // Taylor denominators n*(n+1) for n = 16, 14, ... 2
  localparam int TAYLOR_TERMS = 8;
  localparam longint unsigned TAYLOR_DIV [TAYLOR_TERMS] =
    '{64'd272, 64'd210, 64'd156, 64'd110, 64'd72, 64'd42, 64'd20, 64'd6};

  // One word travelling from front to back
  typedef struct packed {
    logic [PHASE_W-1:0]         phase;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
  } shc_item_t;

  // Queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } shc_queue_status_t;

endpackage

FILE: src/shc_channels.sv
// Valid/ready channel interfaces for sample and result words.
interface shc_in_if;
  logic               valid;
  logic               ready;
  logic [15:0]        sample_angle;
  logic signed [15:0] sample_value;
  logic               last_item;

  modport source (output valid, output sample_angle, output sample_value,
                  output last_item, input ready);
  modport sink   (input valid, input sample_angle, input sample_value,
                  input last_item, output ready);
endinterface

interface shc_out_if;
  logic               valid;
  logic               ready;
  logic signed [52:0] correlation;

  modport source (output valid, output correlation, input ready);
  modport sink   (input valid, input correlation, output ready);
endinterface

FILE: src/shc_front.sv
// Front end: takes sample words and turns each angle into a sine phase.
module shc_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [15:0]           phase_shift_i,
  input  logic [15:0]           harmonic_gain_i,
  shc_in_if.sink                sample_i,
  input  shc_pkg::shc_queue_status_t q_status_i,
  output logic                  push_o,
  output shc_pkg::shc_item_t    item_o
);
  import shc_pkg::*;

  logic                valid_q, valid_d;
  shc_item_t           item_q;
  logic                accept;
  logic [31:0]         scaled_angle;
  logic [PHASE_W-1:0]  phase;

  // Take a word when the holding register is empty or moves on this cycle
  assign sample_i.ready = !valid_q || !q_status_i.full;
  assign accept         = sample_i.valid && sample_i.ready;
  assign push_o         = valid_q && !q_status_i.full;
  assign item_o         = item_q;

  // Phase = shift + floor(gain * angle / 256), wrapping at one turn
  assign scaled_angle = 32'(harmonic_gain_i) * 32'(sample_i.sample_angle);
  assign phase        = phase_shift_i + scaled_angle[23:8];

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (push_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Hold the classified word until the queue takes it
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.phase  <= phase;
      item_q.sample <= sample_i.sample_value;
      item_q.last   <= sample_i.last_item;
    end
  end

endmodule

FILE: src/shc_queue.sv
// Short word queue between the front end and the back end.
module shc_queue (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  shc_pkg::shc_item_t         item_i,
  input  logic                       pop_i,
  output shc_pkg::shc_item_t         item_o,
  output shc_pkg::shc_queue_status_t status_o
);
  import shc_pkg::*;

  shc_item_t           mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0]   count_q, count_d;

  assign status_o.full  = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign status_o.empty = (count_q == '0);
  assign item_o         = mem_q[rd_ptr_q];

  // Advance pointers with wrap, track fill
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store incoming word
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

FILE: src/shc_back.sv
// Back end: sine lookup, products, running sums and the final correlation.
module shc_back #(
  parameter int QUARTER_TABLE_DEPTH = 256
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  shc_pkg::shc_item_t         item_i,
  input  shc_pkg::shc_queue_status_t q_status_i,
  output logic                       pop_o,
  input  logic signed [15:0]         mean_level_i,
  shc_out_if.source                  result_o
);
  import shc_pkg::*;

  localparam int IdxW  = $clog2(QUARTER_TABLE_DEPTH + 1);
  localparam int ScalW = OFFSET_W + IdxW;

  typedef logic [SINE_MAG_W-1:0] qtab_t [QUARTER_TABLE_DEPTH + 1];

  // Entry k: round(32767 * sin(pi/2 * k / D)) via truncating Q30 Taylor series
  function automatic logic [SINE_MAG_W-1:0] quarter_entry(input longint unsigned k);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    longint unsigned s;
    longint unsigned v;
    x  = (HALF_PI_Q30 * k) / QUARTER_TABLE_DEPTH;
    x2 = (x * x) >> 30;
    t  = Q30_ONE;
    for (int j = 0; j < TAYLOR_TERMS; j++) begin
      t = Q30_ONE - (((x2 * t) >> 30) / TAYLOR_DIV[j]);
    end
    s = (x * t) >> 30;
    v = (s * SINE_MAX + Q30_HALF_LSB) >> 30;
    if (v > SINE_MAX) begin
      v = SINE_MAX;
    end
    return v[SINE_MAG_W-1:0];
  endfunction

  function automatic qtab_t build_table();
    qtab_t tab;
    for (int k = 0; k <= QUARTER_TABLE_DEPTH; k++) begin
      tab[k] = quarter_entry(longint'(k));
    end
    return tab;
  endfunction

  localparam qtab_t QTAB = build_table();

  logic advance;

  // Stage 1: table index
  logic                       s1_valid_q;
  logic [IdxW-1:0]            s1_k_q;
  logic                       s1_neg_q;
  logic signed [SAMPLE_W-1:0] s1_sample_q;
  logic                       s1_last_q;
  logic [ScalW-1:0]           scaled_off;
  logic [IdxW-1:0]            idx;
  logic [IdxW-1:0]            k_sel;

  // Stage 2: table read
  logic                       s2_valid_q;
  logic [SINE_MAG_W-1:0]      s2_mag_q;
  logic                       s2_neg_q;
  logic signed [SAMPLE_W-1:0] s2_sample_q;
  logic                       s2_last_q;

  // Stage 3: signed sine and product
  logic                        s3_valid_q;
  logic signed [SAMPLE_W-1:0]  s3_sine_q;
  logic signed [PRODUCT_W-1:0] s3_prod_q;
  logic                        s3_last_q;
  logic signed [SAMPLE_W-1:0]  sine_val;

  // Stage 4: running sums and captured totals
  logic signed [SINE_SUM_W-1:0] sine_sum_q, sine_sum_d;
  logic signed [PROD_SUM_W-1:0] prod_sum_q, prod_sum_d;
  logic signed [SINE_SUM_W-1:0] sine_acc;
  logic signed [PROD_SUM_W-1:0] prod_acc;
  logic                         s4_valid_q;
  logic signed [SINE_SUM_W-1:0] s4_sine_tot_q;
  logic signed [PROD_SUM_W-1:0] s4_prod_tot_q;

  // Stage 5: mean correction product
  logic                          s5_valid_q;
  logic signed [MEAN_PROD_W-1:0] s5_mean_prod_q;
  logic signed [PROD_SUM_W-1:0]  s5_prod_tot_q;

  // Output register
  logic                     out_valid_q;
  logic signed [CORR_W-1:0] out_corr_q;

  // Move the whole pipeline unless a result waits at the output
  assign advance = !out_valid_q || result_o.ready;
  assign pop_o   = advance && !q_status_i.empty;

  assign result_o.valid       = out_valid_q;
  assign result_o.correlation = out_corr_q;

  // Offset to table index, mirrored in odd quadrants
  assign scaled_off = ScalW'(item_i.phase[OFFSET_W-1:0]) * ScalW'(QUARTER_TABLE_DEPTH);
  assign idx        = scaled_off[ScalW-1:OFFSET_W];
  assign k_sel      = item_i.phase[OFFSET_W] ? IdxW'(QUARTER_TABLE_DEPTH) - idx : idx;

  // Negate in the second half-turn, where the top phase bit is set
  assign sine_val = s2_neg_q ? -$signed({1'b0, s2_mag_q}) : $signed({1'b0, s2_mag_q});

  // Accumulate; the marked last word closes the set and restarts from zero
  assign sine_acc = sine_sum_q + SINE_SUM_W'(s3_sine_q);
  assign prod_acc = prod_sum_q + PROD_SUM_W'(s3_prod_q);

  always_comb begin
    sine_sum_d = sine_sum_q;
    prod_sum_d = prod_sum_q;
    if (advance && s3_valid_q) begin
      if (s3_last_q) begin
        sine_sum_d = '0;
        prod_sum_d = '0;
      end else begin
        sine_sum_d = sine_acc;
        prod_sum_d = prod_acc;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      s4_valid_q  <= 1'b0;
      s5_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      sine_sum_q  <= '0;
      prod_sum_q  <= '0;
    end else begin
      if (advance) begin
        s1_valid_q  <= pop_o;
        s2_valid_q  <= s1_valid_q;
        s3_valid_q  <= s2_valid_q;
        s4_valid_q  <= s3_valid_q && s3_last_q;
        s5_valid_q  <= s4_valid_q;
        out_valid_q <= s5_valid_q;
      end
      sine_sum_q <= sine_sum_d;
      prod_sum_q <= prod_sum_d;
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_k_q         <= k_sel;
      s1_neg_q       <= item_i.phase[PHASE_W-1];
      s1_sample_q    <= item_i.sample;
      s1_last_q      <= item_i.last;

      s2_mag_q       <= QTAB[s1_k_q];
      s2_neg_q       <= s1_neg_q;
      s2_sample_q    <= s1_sample_q;
      s2_last_q      <= s1_last_q;

      s3_sine_q      <= sine_val;
      s3_prod_q      <= sine_val * s2_sample_q;
      s3_last_q      <= s2_last_q;

      s4_sine_tot_q  <= sine_acc;
      s4_prod_tot_q  <= prod_acc;

      s5_mean_prod_q <= MEAN_PROD_W'(s4_sine_tot_q) * MEAN_PROD_W'(mean_level_i);
      s5_prod_tot_q  <= s4_prod_tot_q;

      out_corr_q     <= CORR_W'(s5_prod_tot_q) - CORR_W'(s5_mean_prod_q);
    end
  end

endmodule

FILE: src/sine_harmonic_correlator_core.sv
// Top level of the sine harmonic correlator.
//
//   channel    dir  handshake      payload
//   sample_i   in   valid/ready    sample_angle[15:0], sample_value[15:0] s, last_item
//   result_o   out  valid/ready    correlation[52:0] s
//   cfg        in   cfg_we_i       cfg_idx_i[1:0], cfg_data_i[15:0]
//
// Takes one sample word per cycle, sustained, while the output is not stalled.
// After its last-marked word is taken, a result passes through the front register,
// the queue, the five-stage back-end pipeline and the output register.
// Reset clears control, sums and configuration registers at once; the sine table is a ROM.
// A result not taken stalls the back end; the 4-word queue and the front
// register keep taking words until they fill.
module sine_harmonic_correlator_core #(
  parameter int QUARTER_TABLE_DEPTH = 256
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [shc_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [shc_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  shc_in_if.sink                          sample_i,
  shc_out_if.source                       result_o
);
  import shc_pkg::*;

  logic [15:0]        phase_shift_q;
  logic [15:0]        harmonic_gain_q;
  logic signed [15:0] mean_level_q;

  shc_item_t          front_item;
  shc_item_t          queue_item;
  shc_queue_status_t  q_status;
  logic               push;
  logic               pop;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_shift_q   <= '0;
      harmonic_gain_q <= HARMONIC_GAIN_RESET;
      mean_level_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PHASE_SHIFT:   phase_shift_q   <= cfg_data_i;
        CFG_HARMONIC_GAIN: harmonic_gain_q <= cfg_data_i;
        CFG_MEAN_LEVEL:    mean_level_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  shc_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .phase_shift_i   (phase_shift_q),
    .harmonic_gain_i (harmonic_gain_q),
    .sample_i        (sample_i),
    .q_status_i      (q_status),
    .push_o          (push),
    .item_o          (front_item)
  );

  shc_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .item_i   (front_item),
    .pop_i    (pop),
    .item_o   (queue_item),
    .status_o (q_status)
  );

  shc_back #(
    .QUARTER_TABLE_DEPTH (QUARTER_TABLE_DEPTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (queue_item),
    .q_status_i   (q_status),
    .pop_o        (pop),
    .mean_level_i (mean_level_q),
    .result_o     (result_o)
  );

endmodule

FILE: src/shc_checker.sv
// Port-level checks for the correlator, bound to the top level.
`include "sine_harmonic_correlator_core_assert.svh"

module shc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_last,
  input logic        out_valid,
  input logic        out_ready,
  input logic [52:0] out_corr
);

  logic [3:0] pending_q, pending_d;
  logic       last_in;
  logic       word_out;

  // Count last-marked words taken whose result is not yet delivered
  assign last_in  = in_valid && in_ready && in_last;
  assign word_out = out_valid && out_ready;

  always_comb begin
    pending_d = pending_q;
    if (last_in && !word_out) begin
      pending_d = pending_q + 1'b1;
    end else if (word_out && !last_in) begin
      pending_d = pending_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_d;
    end
  end

  `SHC_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid)
  `SHC_ASSERT_NXT(a_out_stable, out_valid && !out_ready, $stable(out_corr))
  `SHC_ASSERT_IMP(a_out_needs_last, out_valid, pending_q != 4'd0)
  `SHC_ASSERT_IMP(a_pending_bound, 1'b1, pending_q <= 4'd12)

endmodule

bind sine_harmonic_correlator_core shc_checker u_shc_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (sample_i.valid),
  .in_ready  (sample_i.ready),
  .in_last   (sample_i.last_item),
  .out_valid (result_o.valid),
  .out_ready (result_o.ready),
  .out_corr  (result_o.correlation)
);

FILE: verif/sine_harmonic_correlator_core_tb.sv
// Testbench for the sine harmonic correlator core: self-checking with a scoreboard class.
module sine_harmonic_correlator_core_tb;
  import shc_pkg::*;

  localparam int TABLE_DEPTH    = 256;
  localparam int SETTLE_CYCLES  = 16;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int LONG_SET_WORDS = 100;
  localparam int RANDOM_PHASES  = 10;
  localparam int PHASE_WORDS    = 183;

  // Predicts each correlation and holds those not yet seen
  class correlation_board;
    logic [15:0]        phase_shift;
    logic [15:0]        harmonic_gain;
    logic signed [15:0] mean_level;
    logic [31:0]        sine_acc;
    logic [47:0]        product_acc;
    logic signed [15:0] quarter_wave [TABLE_DEPTH+1];
    logic [52:0]        pending_corr [$];
    int                 errors;
    int                 words_taken;
    int                 results_seen;

    function new();
      longint unsigned x, x2, t, s, v, n;
      phase_shift   = '0;
      harmonic_gain = HARMONIC_GAIN_RESET;
      mean_level    = '0;
      sine_acc      = '0;
      product_acc   = '0;
      errors        = 0;
      words_taken   = 0;
      results_seen  = 0;
      // Build the quarter-wave table in Q30 with a truncating Taylor series
      for (int k = 0; k <= TABLE_DEPTH; k++) begin
        x  = (64'd1686629713 * longint'(k)) / TABLE_DEPTH;
        x2 = (x * x) >> 30;
        t  = 64'd1 << 30;
        for (n = 16; n >= 2; n -= 2)
          t = (64'd1 << 30) - ((x2 * t) >> 30) / (n * (n + 1));
        s = (x * t) >> 30;
        v = (s * 64'd32767 + (64'd1 << 29)) >> 30;
        if (v > 64'd32767) v = 64'd32767;
        quarter_wave[k] = 16'(v);
      end
    endfunction

    function void write_register(cfg_index_e idx, logic [15:0] data);
      case (idx)
        CFG_PHASE_SHIFT:   phase_shift   = data;
        CFG_HARMONIC_GAIN: harmonic_gain = data;
        CFG_MEAN_LEVEL:    mean_level    = data;
        default: ;
      endcase
    endfunction

    // Accumulate one word; queue a correlation when it closes a set
    function void take_word(logic [15:0] angle, logic signed [15:0] value, logic last);
      logic [31:0]        scaled;
      logic [15:0]        phase;
      int                 idx;
      int                 k;
      logic signed [15:0] sine;
      logic signed [31:0] prod;
      longint signed      full;
      scaled = 32'(harmonic_gain) * 32'(angle);
      phase  = phase_shift + scaled[23:8];
      idx    = (int'(phase[13:0]) * TABLE_DEPTH) >> 14;
      k      = phase[14] ? TABLE_DEPTH - idx : idx;
      sine   = phase[15] ? -quarter_wave[k] : quarter_wave[k];
      prod   = sine * value;
      sine_acc    = sine_acc + {{16{sine[15]}}, sine};
      product_acc = product_acc + {{16{prod[31]}}, prod};
      words_taken++;
      if (last) begin
        full = longint'($signed(product_acc))
             - longint'($signed(sine_acc)) * longint'(mean_level);
        pending_corr.push_back(full[52:0]);
        sine_acc    = '0;
        product_acc = '0;
      end
    endfunction

    function void check_correlation(logic [52:0] actual);
      logic [52:0] want;
      results_seen++;
      if (pending_corr.size() == 0) begin
        errors++;
        $display("%0t: unexpected correlation, expected none, got %0d",
                 $time, $signed(actual));
        return;
      end
      want = pending_corr.pop_front();
      if (actual !== want) begin
        errors++;
        $display("%0t: correlation mismatch, expected %0d, got %0d",
                 $time, $signed(want), $signed(actual));
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [15:0] cfg_data_i;
  bit          quiet;
  int          stuck_cycles;
  int          settings_used;

  correlation_board board;

  shc_in_if  sample_if ();
  shc_out_if result_if ();

  sine_harmonic_correlator_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .sample_i   (sample_if),
    .result_o   (result_if)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // Stall the result side at random unless in a quiet stretch
  always @(negedge clk_i) begin
    result_if.ready <= quiet || ($urandom_range(99) >= 33);
  end

  // Check each result word as it is taken
  always @(posedge clk_i) begin
    if (rst_ni && result_if.valid && result_if.ready)
      board.check_correlation(result_if.correlation);
  end

  // Abort when no word moves for too long
  always @(posedge clk_i) begin
    if ((sample_if.valid && sample_if.ready) || (result_if.valid && result_if.ready))
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("Mismatches found");
      $finish;
    end
  end

  // Offer one sample word and hold it until taken; returns at a falling edge
  task automatic send_word(logic [15:0] angle, logic [15:0] value, logic last);
    if (!quiet) begin
      while ($urandom_range(99) < 33) begin
        sample_if.valid        <= 1'b0;
        sample_if.sample_angle <= 16'($urandom);
        sample_if.sample_value <= 16'($urandom);
        sample_if.last_item    <= 1'($urandom);
        @(negedge clk_i);
      end
    end
    sample_if.valid        <= 1'b1;
    sample_if.sample_angle <= angle;
    sample_if.sample_value <= value;
    sample_if.last_item    <= last;
    @(posedge clk_i);
    while (!sample_if.ready) @(posedge clk_i);
    board.take_word(angle, value, last);
    @(negedge clk_i);
  endtask

  // Drop valid and wait until every correlation is out and the pipe is empty
  task automatic drain();
    sample_if.valid <= 1'b0;
    while (board.pending_corr.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Write all three registers on consecutive cycles; block must be idle
  task automatic write_registers(logic [15:0] shift, logic [15:0] gain, logic [15:0] mean);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_PHASE_SHIFT;
    cfg_data_i <= shift;
    @(negedge clk_i);
    board.write_register(CFG_PHASE_SHIFT, shift);
    cfg_idx_i  <= CFG_HARMONIC_GAIN;
    cfg_data_i <= gain;
    @(negedge clk_i);
    board.write_register(CFG_HARMONIC_GAIN, gain);
    cfg_idx_i  <= CFG_MEAN_LEVEL;
    cfg_data_i <= mean;
    @(negedge clk_i);
    board.write_register(CFG_MEAN_LEVEL, mean);
    cfg_we_i   <= 1'b0;
    settings_used++;
  endtask

  // Pick a register value: often an extreme, otherwise random
  function automatic logic [15:0] pick_value(logic [15:0] lo, logic [15:0] hi);
    int roll;
    roll = $urandom_range(5);
    if (roll == 0) return lo;
    if (roll == 1) return hi;
    return 16'($urandom);
  endfunction

  // Random words grouped into sets of random length
  task automatic run_random(int words);
    int set_len;
    int in_set;
    logic last;
    set_len = 0;
    in_set  = 0;
    for (int w = 0; w < words; w++) begin
      if (in_set == 0) begin
        case ($urandom_range(7))
          0:       set_len = 1;
          1:       set_len = $urandom_range(30, 80);
          default: set_len = $urandom_range(2, 16);
        endcase
      end
      in_set++;
      last = (in_set >= set_len);
      if (w == words - 1 && $urandom_range(3) != 0) last = 1'b1;
      if (last) in_set = 0;
      send_word(16'($urandom), 16'($urandom), last);
    end
  endtask

  initial begin
    int errors;
    board         = new();
    quiet         = 1'b0;
    stuck_cycles  = 0;
    settings_used = 0;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_PHASE_SHIFT;
    cfg_data_i    = '0;
    sample_if.valid        = 1'b0;
    sample_if.sample_angle = '0;
    sample_if.sample_value = '0;
    sample_if.last_item    = 1'b0;
    result_if.ready        = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset values: one-word set, then the quadrant boundaries and full-scale samples
    send_word(16'd0,     16'sd32767,  1'b1);
    send_word(16'd16384, -16'sd32768, 1'b0);
    send_word(16'd32768, 16'sd32767,  1'b0);
    send_word(16'd49152, -16'sd32768, 1'b0);
    send_word(16'd65535, 16'sd1,      1'b1);
    send_word(16'd8192,  -16'sd1,     1'b0);
    send_word(16'd24576, 16'sd0,      1'b0);
    send_word(16'd40960, 16'sd12345,  1'b0);
    send_word(16'd57344, -16'sd12345, 1'b1);
    drain();

    // Register extremes at the top end and with zero gain
    write_registers(16'hFFFF, 16'hFFFF, 16'h8000);
    send_word(16'd65535, 16'sd32767,  1'b0);
    send_word(16'd1,     -16'sd32768, 1'b0);
    send_word(16'd32768, -16'sd1,     1'b1);
    drain();
    write_registers(16'h0000, 16'h0000, 16'h7FFF);
    send_word(16'd12345, 16'sd32767,  1'b0);
    send_word(16'd65535, -16'sd32768, 1'b1);
    drain();

    // Open set carried across a register change
    write_registers(16'h3FFF, 16'h0080, 16'h0001);
    send_word(16'd16383, 16'sd100,  1'b0);
    send_word(16'd49151, -16'sd100, 1'b0);
    send_word(16'd100,   16'sd5,    1'b0);
    drain();
    write_registers(16'h8000, 16'h0200, 16'hFFFF);
    send_word(16'd300, 16'sd7, 1'b1);
    drain();

    // Long set: peak sine against full negative samples, back to back
    write_registers(16'h0000, HARMONIC_GAIN_RESET, 16'h3039);
    quiet = 1'b1;
    for (int w = 0; w < LONG_SET_WORDS; w++)
      send_word(16'd16384, -16'sd32768, w == LONG_SET_WORDS - 1);
    quiet = 1'b0;
    drain();

    // Random phases, each under its own register setting; one without stalls
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      write_registers(pick_value(16'h0000, 16'hFFFF), pick_value(16'h0000, 16'hFFFF),
                      pick_value(16'h8000, 16'h7FFF));
      quiet = (ph == 4);
      run_random(PHASE_WORDS);
      drain();
    end
    quiet = 1'b0;

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    errors = board.errors + board.pending_corr.size();
    $display("Covered %0d sample words and %0d correlations over %0d register settings,",
             board.words_taken, board.results_seen, settings_used + 1);
    $display("including one long set of peak sines against full negative samples.");
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
